### hw/rtl/pbm_pkg.sv
package pbm_pkg;

    localparam int IMAGE_DIM_DEF   = 64;
    localparam int MAX_PATCH_DEF   = 8;
    localparam int MAX_HALF_DEF    = 8;
    localparam int MAX_MATCHES_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int COORD_W    = 8;
    localparam int DIST_OUT_W = 22;

    localparam logic [CFG_IDX_W-1:0] REG_PATCH_SIZE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_HALF     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MATCHES     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd5;

    localparam logic [3:0]  RST_PATCH_SIZE      = 4'd5;
    localparam logic [3:0]  RST_SEARCH_HALF     = 4'd6;
    localparam logic [5:0]  RST_MAX_MATCHES     = 6'd16;
    localparam logic [21:0] RST_MATCH_THRESHOLD = 22'd40000;
    localparam logic [6:0]  RST_IMAGE_WIDTH     = 7'd22;
    localparam logic [6:0]  RST_IMAGE_HEIGHT    = 7'd22;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DECIDE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clr;
        logic ins;
        logic shift;
    } t_chain_ctl;

endpackage

### hw/rtl/patch_block_matching.sv
// channel   valid      stall      payload
// input     i_valid    o_stall    i_operation i_row i_col i_pixel_value
// output    o_valid    i_stall    o_match_row o_match_col o_distance o_status o_last
// config    i_cfg_we   -          i_cfg_idx i_cfg_data
//
// a query does the sum-of-squares walk over each of the (2*hw + 1)**2 window candidates,
// one image pixel pair per cycle from the two image read ports while in ST_RUN,
// then emits its result beats, each held while i_stall is high.
// a passing candidate is sorted into the insertion chain from ST_DECIDE.
// reset is synchronous; the image store holds no reset and needs no clearing pass.
// o_stall is high from a query beat until its last result beat is taken.
module patch_block_matching #(
    parameter int IMAGE_DIM       = pbm_pkg::IMAGE_DIM_DEF,
    parameter int MAX_PATCH       = pbm_pkg::MAX_PATCH_DEF,
    parameter int MAX_HALF_WINDOW = pbm_pkg::MAX_HALF_DEF,
    parameter int MAX_MATCHES     = pbm_pkg::MAX_MATCHES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_operation,
    input  logic [5:0]                     i_row,
    input  logic [5:0]                     i_col,
    input  logic [7:0]                     i_pixel_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [5:0]                     o_match_row,
    output logic [5:0]                     o_match_col,
    output logic [21:0]                    o_distance,
    output logic                           o_status,
    output logic                           o_last,
    input  logic                           i_cfg_we,
    input  logic [pbm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pbm_pkg::*;

    localparam int AW   = $clog2(IMAGE_DIM);
    localparam int PW   = $clog2(MAX_PATCH + 1);
    localparam int WW   = $clog2(2 * MAX_HALF_WINDOW + 1);
    localparam int FW   = $clog2((2 * MAX_HALF_WINDOW + 1) * (2 * MAX_HALF_WINDOW + 1) + 1);
    localparam int NW   = $clog2(MAX_MATCHES + 1);
    localparam int ACW  = $clog2(MAX_PATCH * MAX_PATCH * 65025 + 1);
    localparam int DW   = (ACW > DIST_OUT_W) ? ACW : DIST_OUT_W;

    logic [3:0]  r_patch_size, r_search_half;
    logic [5:0]  r_max_matches;
    logic [21:0] r_threshold;
    logic [6:0]  r_image_width, r_image_height;

    t_state r_state, n_state;
    logic [5:0]    r_row, r_col;
    logic [WW-1:0] r_wi, r_wj;
    logic [PW-1:0] r_p, r_q;
    logic [FW-1:0] r_found;
    logic [NW-1:0] r_emit;
    logic          r_err;

    logic [4:0]  ps5, hw5;
    logic [6:0]  cap7;
    logic [10:0] iw11, ih11;
    logic        win_bad, in_acc, out_acc;

    logic [COORD_W-1:0] cand_r, cand_c, ref_pr, ref_pc, cnd_pr, cnd_pc;
    logic [2*AW-1:0] addr_a, addr_b, waddr;
    logic            issue, first, busy, we;
    logic [ACW-1:0]  acc;
    logic            pass, last_cand, last_pix_q, last_pix_p;

    t_chain_ctl ctl;
    logic [5:0]    ins_r, ins_c;
    logic [DW-1:0] ins_d, head_d;
    logic [5:0]    head_r, head_c;

    logic [FW-1:0] found_eff, pf;
    logic [NW-1:0] n_cnt;
    logic          last_beat;

    // register clamps
    always_comb begin
        ps5  = (r_patch_size == 4'd0) ? 5'd1 :
               ({1'b0, r_patch_size} > 5'(MAX_PATCH)) ? 5'(MAX_PATCH) : {1'b0, r_patch_size};
        hw5  = ({1'b0, r_search_half} > 5'(MAX_HALF_WINDOW)) ? 5'(MAX_HALF_WINDOW)
                                                             : {1'b0, r_search_half};
        cap7 = (r_max_matches == 6'd0) ? 7'd1 :
               ({1'b0, r_max_matches} > 7'(MAX_MATCHES)) ? 7'(MAX_MATCHES)
                                                         : {1'b0, r_max_matches};
        iw11 = ({4'b0, r_image_width} > 11'(IMAGE_DIM)) ? 11'(IMAGE_DIM)
                                                        : {4'b0, r_image_width};
        ih11 = ({4'b0, r_image_height} > 11'(IMAGE_DIM)) ? 11'(IMAGE_DIM)
                                                         : {4'b0, r_image_height};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_size   <= RST_PATCH_SIZE;
            r_search_half  <= RST_SEARCH_HALF;
            r_max_matches  <= RST_MAX_MATCHES;
            r_threshold    <= RST_MATCH_THRESHOLD;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PATCH_SIZE:      r_patch_size   <= i_cfg_data[3:0];
                REG_SEARCH_HALF:     r_search_half  <= i_cfg_data[3:0];
                REG_MAX_MATCHES:     r_max_matches  <= i_cfg_data[5:0];
                REG_MATCH_THRESHOLD: r_threshold    <= i_cfg_data[21:0];
                REG_IMAGE_WIDTH:     r_image_width  <= i_cfg_data[6:0];
                REG_IMAGE_HEIGHT:    r_image_height <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    assign win_bad = ({5'b0, i_row} < {6'b0, hw5}) || ({5'b0, i_col} < {6'b0, hw5}) ||
                     ({5'b0, i_row} + {6'b0, hw5} + {6'b0, ps5} > ih11) ||
                     ({5'b0, i_col} + {6'b0, hw5} + {6'b0, ps5} > iw11);

    // addresses of the current pixel pair
    always_comb begin
        cand_r = {2'b0, r_row} + COORD_W'(r_wi) - {3'b0, hw5};
        cand_c = {2'b0, r_col} + COORD_W'(r_wj) - {3'b0, hw5};
        ref_pr = {2'b0, r_row} + COORD_W'(r_p);
        ref_pc = {2'b0, r_col} + COORD_W'(r_q);
        cnd_pr = cand_r + COORD_W'(r_p);
        cnd_pc = cand_c + COORD_W'(r_q);
    end

    assign addr_a = {AW'(ref_pr), AW'(ref_pc)};
    assign addr_b = {AW'(cnd_pr), AW'(cnd_pc)};
    assign waddr  = {AW'(i_row), AW'(i_col)};
    assign we     = in_acc && (i_operation == OP_LOAD) &&
                    ({5'b0, i_row} < 11'(IMAGE_DIM)) && ({5'b0, i_col} < 11'(IMAGE_DIM));
    assign issue  = (r_state == ST_RUN);
    assign first  = (r_p == '0) && (r_q == '0);

    pbm_ssd #(.AW(AW), .ACW(ACW)) u_ssd (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (i_pixel_value),
        .i_issue   (issue),
        .i_first   (first),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_busy    (busy),
        .o_acc     (acc)
    );

    assign pass       = (DW'(acc) < DW'(r_threshold));
    assign last_pix_q = (5'(r_q) == ps5 - 5'd1);
    assign last_pix_p = (5'(r_p) == ps5 - 5'd1);
    assign last_cand  = (5'(r_wi) == {hw5[3:0], 1'b0}) && (5'(r_wj) == {hw5[3:0], 1'b0});

    // result count: cap, or the largest power of two not above the number found
    always_comb begin
        found_eff = (r_found == '0) ? FW'(1) : r_found;
        pf = FW'(1);
        for (int k = 0; k < FW; k++) begin
            if (found_eff[k]) begin
                pf = FW'(1) << k;
            end
        end
        n_cnt = ({9'b0, found_eff} >= (FW + 9)'(cap7)) ? NW'(cap7) : NW'(pf);
    end

    assign last_beat = r_err || ((n_cnt == NW'(1)) ? (r_emit == NW'(1))
                                                   : (r_emit == n_cnt - NW'(1)));

    always_comb begin
        n_state   = r_state;
        ctl       = '0;
        ins_r     = 6'(cand_r);
        ins_c     = 6'(cand_c);
        ins_d     = DW'(acc);
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_operation == OP_QUERY) begin
                    ctl.clr = 1'b1;
                    n_state = win_bad ? ST_OUT : ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_pix_q && last_pix_p) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!busy) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (pass) begin
                    ctl.ins = 1'b1;
                end else if (last_cand && r_found == '0) begin
                    // nothing passed: the reference patch stands in at distance zero
                    ctl.ins = 1'b1;
                    ins_r   = r_row;
                    ins_c   = r_col;
                    ins_d   = '0;
                end
                n_state = last_cand ? ST_OUT : ST_RUN;
            end
            ST_OUT: begin
                if (out_acc) begin
                    if (last_beat) begin
                        n_state = ST_IDLE;
                    end else if (n_cnt != NW'(1)) begin
                        ctl.shift = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_row   <= i_row;
                r_col   <= i_col;
                r_wi    <= '0;
                r_wj    <= '0;
                r_p     <= '0;
                r_q     <= '0;
                r_found <= '0;
                r_emit  <= '0;
                r_err   <= win_bad;
            end
            ST_RUN: begin
                if (last_pix_q) begin
                    r_q <= '0;
                    r_p <= last_pix_p ? '0 : r_p + PW'(1);
                end else begin
                    r_q <= r_q + PW'(1);
                end
            end
            ST_DECIDE: begin
                if (pass) begin
                    r_found <= r_found + FW'(1);
                end
                if (5'(r_wj) == {hw5[3:0], 1'b0}) begin
                    r_wj <= '0;
                    r_wi <= r_wi + WW'(1);
                end else begin
                    r_wj <= r_wj + WW'(1);
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    r_emit <= r_emit + NW'(1);
                end
            end
            default: ;
        endcase
    end

    pbm_chain #(.DEPTH(MAX_MATCHES), .DW(DW)) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_ins_r  (ins_r),
        .i_ins_c  (ins_c),
        .i_ins_d  (ins_d),
        .o_head_r (head_r),
        .o_head_c (head_c),
        .o_head_d (head_d)
    );

    assign o_valid     = (r_state == ST_OUT);
    assign o_match_row = r_err ? 6'd0 : head_r;
    assign o_match_col = r_err ? 6'd0 : head_c;
    assign o_distance  = r_err ? 22'd0 : head_d[DIST_OUT_W-1:0];
    assign o_status    = r_err;
    assign o_last      = last_beat;

endmodule

### hw/rtl/pbm_ssd.sv
module pbm_ssd #(
    parameter int AW  = 6,
    parameter int ACW = 22
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_we,
    input  logic [2*AW-1:0] i_waddr,
    input  logic [7:0]      i_wdata,
    input  logic            i_issue,
    input  logic            i_first,
    input  logic [2*AW-1:0] i_raddr_a,
    input  logic [2*AW-1:0] i_raddr_b,
    output logic            o_busy,
    output logic [ACW-1:0]  o_acc
);
    import pbm_pkg::*;

    logic [7:0] r_mem [2**(2*AW)];
    logic [7:0] r_a, r_b;
    logic r_v1, r_v2, r_f1, r_f2;
    logic signed [8:0] diff;
    logic signed [17:0] sq;
    logic [15:0] r_sq;
    logic [ACW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_a <= r_mem[i_raddr_a];
        r_b <= r_mem[i_raddr_b];
    end

    assign diff = $signed({1'b0, r_a}) - $signed({1'b0, r_b});
    assign sq   = diff * diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1 <= i_first;
        r_f2 <= r_f1;
        r_sq <= sq[15:0];
        if (r_v2) begin
            r_acc <= r_f2 ? ACW'(r_sq) : r_acc + ACW'(r_sq);
        end
    end

    assign o_busy = r_v1 | r_v2;
    assign o_acc  = r_acc;

endmodule

### hw/rtl/pbm_cell.sv
module pbm_cell #(
    parameter int DW = 22
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pbm_pkg::t_chain_ctl     i_ctl,
    input  logic [5:0]              i_ins_r,
    input  logic [5:0]              i_ins_c,
    input  logic [DW-1:0]           i_ins_d,
    input  logic                    i_prev_valid,
    input  logic                    i_prev_keep,
    input  logic [5:0]              i_prev_r,
    input  logic [5:0]              i_prev_c,
    input  logic [DW-1:0]           i_prev_d,
    input  logic                    i_next_valid,
    input  logic [5:0]              i_next_r,
    input  logic [5:0]              i_next_c,
    input  logic [DW-1:0]           i_next_d,
    output logic                    o_valid,
    output logic                    o_keep,
    output logic [5:0]              o_r,
    output logic [5:0]              o_c,
    output logic [DW-1:0]           o_d
);
    import pbm_pkg::*;

    logic r_valid;
    logic [5:0] r_r, r_c;
    logic [DW-1:0] r_d;

    // equal distances stay ahead of the newcomer to keep scan order
    assign o_keep = r_valid && (r_d <= i_ins_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clr) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins && !o_keep) begin
            r_valid <= i_prev_keep ? 1'b1 : i_prev_valid;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !o_keep) begin
            if (i_prev_keep) begin
                r_r <= i_ins_r;
                r_c <= i_ins_c;
                r_d <= i_ins_d;
            end else begin
                r_r <= i_prev_r;
                r_c <= i_prev_c;
                r_d <= i_prev_d;
            end
        end else if (i_ctl.shift) begin
            r_r <= i_next_r;
            r_c <= i_next_c;
            r_d <= i_next_d;
        end
    end

    assign o_valid = r_valid;
    assign o_r     = r_r;
    assign o_c     = r_c;
    assign o_d     = r_d;

endmodule

### hw/rtl/pbm_chain.sv
module pbm_chain #(
    parameter int DEPTH = 32,
    parameter int DW    = 22
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbm_pkg::t_chain_ctl i_ctl,
    input  logic [5:0]          i_ins_r,
    input  logic [5:0]          i_ins_c,
    input  logic [DW-1:0]       i_ins_d,
    output logic [5:0]          o_head_r,
    output logic [5:0]          o_head_c,
    output logic [DW-1:0]       o_head_d
);
    import pbm_pkg::*;

    logic          valid [DEPTH+1];
    logic          keep  [DEPTH];
    logic [5:0]    rr    [DEPTH+1];
    logic [5:0]    cc    [DEPTH+1];
    logic [DW-1:0] dd    [DEPTH+1];

    // slot DEPTH is an empty tail feeding the last cell on shift
    assign valid[DEPTH] = 1'b0;
    assign rr[DEPTH]    = '0;
    assign cc[DEPTH]    = '0;
    assign dd[DEPTH]    = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic          pv, pk;
        logic [5:0]    pr, pc;
        logic [DW-1:0] pd;
        if (g == 0) begin : g_head
            assign pv = 1'b1;
            assign pk = 1'b1;
            assign pr = '0;
            assign pc = '0;
            assign pd = '0;
        end else begin : g_body
            assign pv = valid[g-1];
            assign pk = keep[g-1];
            assign pr = rr[g-1];
            assign pc = cc[g-1];
            assign pd = dd[g-1];
        end
        pbm_cell #(.DW(DW)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_ins_r      (i_ins_r),
            .i_ins_c      (i_ins_c),
            .i_ins_d      (i_ins_d),
            .i_prev_valid (pv),
            .i_prev_keep  (pk),
            .i_prev_r     (pr),
            .i_prev_c     (pc),
            .i_prev_d     (pd),
            .i_next_valid (valid[g+1]),
            .i_next_r     (rr[g+1]),
            .i_next_c     (cc[g+1]),
            .i_next_d     (dd[g+1]),
            .o_valid      (valid[g]),
            .o_keep       (keep[g]),
            .o_r          (rr[g]),
            .o_c          (cc[g]),
            .o_d          (dd[g])
        );
    end

    assign o_head_r = rr[0];
    assign o_head_c = cc[0];
    assign o_head_d = dd[0];

endmodule
